### rtl/tefr_pkg.sv
package tefr_pkg;

  // Storage and arithmetic widths.
  localparam int DEFAULT_FIFO_DEPTH = 64;
  localparam int COORD_W            = 32;
  localparam int RES_W              = 16;
  localparam int USEC_W             = 20;
  localparam int TIME_W             = 14;
  localparam int POS_W              = 2 * COORD_W;
  localparam int PT_W               = COORD_W + TIME_W;
  localparam int DIVIDEND_W         = 48;
  localparam int DIVISOR_W          = 32;
  localparam int CFG_INDEX_W        = 3;

  // Reset values of the resolution registers.
  localparam logic [RES_W-1:0] X_RES_RESET = 16'd240;
  localparam logic [RES_W-1:0] Y_RES_RESET = 16'd320;

  // Reciprocal of 100 for the timestamp: ceil(2^27 / 100), exact for 20-bit inputs.
  localparam int          TIME_SHIFT = 27;
  localparam logic [20:0] TIME_RECIP = 21'd1342178;

  // Command codes.
  localparam logic [2:0] CMD_ABS   = 3'd0;
  localparam logic [2:0] CMD_REL   = 3'd1;
  localparam logic [2:0] CMD_KEY   = 3'd2;
  localparam logic [2:0] CMD_OTHER = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Event codes.
  localparam logic [2:0] CODE_X     = 3'd0;
  localparam logic [2:0] CODE_Y     = 3'd1;
  localparam logic [2:0] CODE_PRESS = 3'd2;
  localparam logic [2:0] CODE_TOUCH = 3'd3;

  // Key states.
  localparam logic [31:0] KEY_UP     = 32'd0;
  localparam logic [31:0] KEY_DOWN   = 32'd1;
  localparam logic [31:0] KEY_REPEAT = 32'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_X_RES    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_RES    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_X_MIN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_X_MAX    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_MIN    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_MAX    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_MIN = 3'd6;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_PUSH,
    ST_READ,
    ST_READ_DATA
  } state_t;

  // Request to the divider.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

endpackage

### rtl/touch_event_to_report_fifo_top.sv
// Items are taken one at a time: the next is accepted only once the sequencer is idle again.
// An event is executed, and an absolute axis event with a positive span is first multiplied
// and divided (48-step bit-serial divider) before its report is stored; a read loads an empty
// beat or pops one report into the output register, and stalls while that register is full.
// Reset (synchronous, active high) restores the register defaults and clears the pen state,
// position, pointers and count; the FIFO memory is not cleared.
module touch_event_to_report_fifo_top #(
  parameter int FIFO_DEPTH = tefr_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration port.
  input  logic                                  cfg_we,
  input  logic [tefr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [31:0]                           cfg_data,
  // Event channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            cmd,
  input  logic [2:0]                            code,
  input  logic signed [31:0]                    value,
  input  logic [tefr_pkg::USEC_W-1:0]           time_usec,
  // Report channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  has_report,
  output logic [31:0]                           report_pressure,
  output logic signed [31:0]                    report_x,
  output logic signed [31:0]                    report_y,
  output logic [tefr_pkg::TIME_W-1:0]           report_time
);

  import tefr_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST   = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);

  // Configuration registers.
  logic [RES_W-1:0]   x_res, y_res;
  logic signed [31:0] x_min, x_max, y_min, y_max, press_min;

  // Pen state.
  logic [31:0]        pen_pressure, pen_pressure_next;
  logic signed [31:0] current_x, current_x_next;
  logic signed [31:0] current_y, current_y_next;

  // FIFO control.
  logic [AW-1:0] write_pointer, read_pointer;
  logic [CW-1:0] entry_count;
  logic          fifo_full;

  // Latched item.
  logic [2:0]         item_cmd, item_code;
  logic signed [31:0] item_value;
  logic [TIME_W-1:0]  item_time;
  logic [40:0]        time_prod;

  state_t state, state_next;

  // Axis selection and arithmetic.
  logic               axis_x;
  logic signed [31:0] sel_min, sel_max, sel_cur;
  logic [RES_W-1:0]   sel_res;
  logic signed [32:0] off, span, rel_sum;
  logic               span_pos;
  logic signed [31:0] clamped;
  logic signed [49:0] prod;
  logic [49:0]        prod_abs;
  logic               prod_neg;
  logic signed [31:0] scaled;

  // Divider.
  div_req_t              div_req;
  logic                  div_done;
  logic [DIVISOR_W-1:0]  div_quo;

  // Sequencer outputs.
  logic push, pop, load_empty, load_data;
  logic [POS_W-1:0] pos_rdata;
  logic [PT_W-1:0]  pt_rdata;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_res     <= X_RES_RESET;
      y_res     <= Y_RES_RESET;
      x_min     <= '0;
      x_max     <= '0;
      y_min     <= '0;
      y_max     <= '0;
      press_min <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_RES:     x_res     <= cfg_data[RES_W-1:0];
        REG_Y_RES:     y_res     <= cfg_data[RES_W-1:0];
        REG_X_MIN:     x_min     <= cfg_data;
        REG_X_MAX:     x_max     <= cfg_data;
        REG_Y_MIN:     y_min     <= cfg_data;
        REG_Y_MAX:     y_max     <= cfg_data;
        REG_PRESS_MIN: press_min <= cfg_data;
        default: ;
      endcase
    end
  end

  // Timestamp in units of 100 us by reciprocal multiplication.
  assign time_prod = {21'b0, time_usec} * {20'b0, TIME_RECIP};

  // Capture the beat on acceptance.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_cmd   <= cmd;
      item_code  <= code;
      item_value <= value;
      item_time  <= time_prod[TIME_SHIFT+TIME_W-1:TIME_SHIFT];
    end
  end

  // Per-axis operands for the scaling and clamping paths.
  always_comb begin
    axis_x   = (item_code == CODE_X);
    sel_min  = axis_x ? x_min : y_min;
    sel_max  = axis_x ? x_max : y_max;
    sel_res  = axis_x ? x_res : y_res;
    sel_cur  = axis_x ? current_x : current_y;
    off      = {item_value[31], item_value} - {sel_min[31], sel_min};
    span     = {sel_max[31], sel_max} - {sel_min[31], sel_min};
    span_pos = !span[32] && (span != '0);
    rel_sum  = {sel_cur[31], sel_cur} + {item_value[31], item_value};
    if (rel_sum[32]) begin
      clamped = '0;
    end else if (rel_sum[31:0] > {16'b0, sel_res}) begin
      clamped = {16'b0, sel_res};
    end else begin
      clamped = rel_sum[31:0];
    end
  end

  // Product register between the multiplier and the divider.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= off * $signed({1'b0, sel_res});
    end
  end

  assign prod_neg = prod[49];
  assign prod_abs = prod_neg ? 50'(-prod) : prod;

  always_comb begin
    div_req.start    = (state == ST_DSTART);
    div_req.dividend = prod_abs[DIVIDEND_W-1:0];
    div_req.divisor  = span[DIVISOR_W-1:0];
  end

  tefr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Truncation toward zero: divide magnitudes, then restore the sign.
  assign scaled = prod_neg ? 32'(-div_quo) : div_quo;

  assign fifo_full = (entry_count == FULL_COUNT);
  assign in_ready  = (state == ST_IDLE);

  // Next state and the state updates of each command.
  always_comb begin
    state_next        = state;
    pen_pressure_next = pen_pressure;
    current_x_next    = current_x;
    current_y_next    = current_y;
    push              = 1'b0;
    pop               = 1'b0;
    load_empty        = 1'b0;
    load_data         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_PUSH;
        unique case (item_cmd)
          CMD_ABS: begin
            if (item_code == CODE_X || item_code == CODE_Y) begin
              if (pen_pressure == '0) begin
                state_next = ST_IDLE;
              end else if (span_pos) begin
                state_next = ST_MUL;
              end else if (axis_x) begin
                current_x_next = off[31:0];
              end else begin
                current_y_next = off[31:0];
              end
            end else if (item_code == CODE_PRESS) begin
              pen_pressure_next = (item_value > press_min) ? 32'(item_value - press_min) : '0;
            end
          end
          CMD_REL: begin
            if (item_code == CODE_X || item_code == CODE_Y) begin
              if (pen_pressure == '0) begin
                state_next = ST_IDLE;
              end else if (axis_x) begin
                current_x_next = clamped;
              end else begin
                current_y_next = clamped;
              end
            end
          end
          CMD_KEY: begin
            if (item_code != CODE_TOUCH) begin
              state_next = ST_IDLE;
            end else if (item_value == KEY_UP) begin
              pen_pressure_next = '0;
            end else if (item_value == KEY_DOWN) begin
              if (pen_pressure == '0) begin
                pen_pressure_next = 32'd1;
              end
            end else if (item_value == KEY_REPEAT) begin
              state_next = ST_IDLE;
            end
          end
          CMD_OTHER: state_next = ST_PUSH;
          CMD_READ:  state_next = ST_READ;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_MUL:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (axis_x) begin
            current_x_next = scaled;
          end else begin
            current_y_next = scaled;
          end
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        push       = !fifo_full;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        // Wait until the output register is free.
        if (!out_valid || out_ready) begin
          if (entry_count == '0) begin
            load_empty = 1'b1;
            state_next = ST_IDLE;
          end else begin
            pop        = 1'b1;
            state_next = ST_READ_DATA;
          end
        end
      end
      ST_READ_DATA: begin
        load_data  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, pen and FIFO control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pen_pressure  <= '0;
      current_x     <= '0;
      current_y     <= '0;
      write_pointer <= '0;
      read_pointer  <= '0;
      entry_count   <= '0;
    end else begin
      state        <= state_next;
      pen_pressure <= pen_pressure_next;
      current_x    <= current_x_next;
      current_y    <= current_y_next;
      if (push) begin
        write_pointer <= (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
      end
      if (pop) begin
        read_pointer <= (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;
      end
      if (push) begin
        entry_count <= entry_count + 1'b1;
      end else if (pop) begin
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  // Report storage: position and pressure/time halves.
  tefr_ram #(
    .WIDTH (POS_W),
    .DEPTH (FIFO_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (push),
    .waddr (write_pointer),
    .wdata ({current_x, current_y}),
    .re    (pop),
    .raddr (read_pointer),
    .rdata (pos_rdata)
  );

  tefr_ram #(
    .WIDTH (PT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_pt_ram (
    .clk   (clk),
    .we    (push),
    .waddr (write_pointer),
    .wdata ({pen_pressure, item_time}),
    .re    (pop),
    .raddr (read_pointer),
    .rdata (pt_rdata)
  );

  // Output register: holds one report beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_empty || load_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_empty) begin
      has_report      <= 1'b0;
      report_pressure <= '0;
      report_x        <= '0;
      report_y        <= '0;
      report_time     <= '0;
    end else if (load_data) begin
      has_report      <= 1'b1;
      report_pressure <= pt_rdata[PT_W-1:TIME_W];
      report_x        <= pos_rdata[POS_W-1:COORD_W];
      report_y        <= pos_rdata[COORD_W-1:0];
      report_time     <= pt_rdata[TIME_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_COUNT)
    else $error("FIFO count exceeds depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH && !fifo_full) |=> entry_count == $past(entry_count) + 1'b1)
    else $error("stored report not counted");

  a_read_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ_DATA |-> $past(state) == ST_READ && $past(entry_count) != '0)
    else $error("memory read without a pending pop");

endmodule

### rtl/tefr_ram.sv
module tefr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tefr_div.sv
module tefr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  tefr_pkg::div_req_t                req,
  output logic                              done,
  output logic [tefr_pkg::DIVISOR_W-1:0]    quotient
);

  import tefr_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  dvs;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  qbit;
  logic [DIVISOR_W-1:0]  rem_next;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial    = {rem, quo[DIVIDEND_W-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  // Iteration control: one quotient bit per cycle, done pulses after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIVIDEND_W-2:0], qbit};
    end
  end

  // The caller keeps the low bits, which is the wrapped position.
  assign quotient = quo[DIVISOR_W-1:0];

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a running division");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0) && (cnt <= CNT_W'(DIVIDEND_W)))
    else $error("divider iteration count out of range");

endmodule
